@@ sv/two_axis_stick_conditioner_core_macros.svh @@
// Assertion macros shared by the stick conditioner checker.
`ifndef TWO_AXIS_STICK_CONDITIONER_CORE_MACROS_SVH
`define TWO_AXIS_STICK_CONDITIONER_CORE_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define STC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion on the default clock and reset port names.
`define STC_ASSERT(label, prop, msg) \
  `STC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

@@ sv/stc_pkg.sv @@
// Package with the shared constants and codes of the stick conditioner.
package stc_pkg;

  localparam int ADC_BITS_DEF      = 12;
  localparam int FRACTION_BITS_DEF = 14;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int ZONE_W     = 15;
  localparam int COUNT_W    = 16;
  localparam int WEIGHT_W   = 17;
  localparam int VALUE_W    = 16;

  localparam logic [ZONE_W-1:0]   DEAD_ZONE_RST  = 15'd819;
  localparam logic [ZONE_W-1:0]   ALIVE_ZONE_RST = 15'd32767;
  localparam logic [COUNT_W-1:0]  CAL_COUNT_RST  = 16'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE     = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEAD_ZONE  = 2'd0,
    CFG_ALIVE_ZONE = 2'd1,
    CFG_CAL_COUNT  = 2'd2,
    CFG_CAL_WEIGHT = 2'd3
  } cfg_index_e;

  typedef enum logic {
    OP_SAMPLE    = 1'b0,
    OP_CAL_START = 1'b1
  } op_e;

endpackage

@@ sv/stc_if.sv @@
// Valid/ready channel interfaces for samples, results and register writes.
interface stc_in_if #(
  parameter int ADC_BITS = stc_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                op;
  logic [ADC_BITS-1:0] x_sample;
  logic [ADC_BITS-1:0] y_sample;

  modport source (output valid, op, x_sample, y_sample, input ready);
  modport sink   (input valid, op, x_sample, y_sample, output ready);
endinterface

interface stc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [stc_pkg::VALUE_W-1:0] x_value;
  logic signed [stc_pkg::VALUE_W-1:0] y_value;
  logic                                calibrating;

  modport source (output valid, x_value, y_value, calibrating, input ready);
  modport sink   (input valid, x_value, y_value, calibrating, output ready);
endinterface

interface stc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [stc_pkg::CFG_IDX_W-1:0]  index;
  logic [stc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/two_axis_stick_conditioner_core.sv @@
// Top level of the two-axis stick conditioner: calibration, marks and division.
//
//   Channel  Direction  Carries
//   in_i     sink       op, x_sample, y_sample
//   out_o    source     x_value, y_value, calibrating
//   cfg_i    sink       index, data (dead_zone, alive_zone, cal_count, cal_weight)
//
// A calibration start yields no result and leaves the core ready for the next pair.
// A sample pair passes per axis, x then y, through S_MUL and S_ACC while calibration
// averages, then S_MARK, S_DIV and S_ZONE, and then waits in S_DONE for the output
// register; in_i takes no new pair until the core is back in idle. The restoring
// divider yields one quotient bit per cycle and is shared by both axes. An axis whose
// sample sits on the centre or whose span is zero skips its divider pass.
// The result sits in an output register, so out_o may stall while the next
// pair is being worked on; the finished pair then waits until that register frees.
// Reset is asynchronous and active low; no clearing pass is needed.
module two_axis_stick_conditioner_core #(
  parameter int ADC_BITS      = stc_pkg::ADC_BITS_DEF,
  parameter int FRACTION_BITS = stc_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stc_in_if.sink    in_i,
  stc_out_if.source out_o,
  stc_cfg_if.sink   cfg_i
);

  localparam int A      = ADC_BITS;
  localparam int F      = FRACTION_BITS;
  // Dividend width: the axis distance shifted up by the fraction bits.
  localparam int N      = A + F;
  localparam int CNT_W  = $clog2(N);
  localparam int PROD_W = A + 19;
  localparam int MAG_W  = F + 1;
  localparam int CMP_W  = (MAG_W > stc_pkg::ZONE_W) ? MAG_W : stc_pkg::ZONE_W;
  localparam int V_W    = (MAG_W > stc_pkg::VALUE_W) ? MAG_W : stc_pkg::VALUE_W;

  localparam logic [A-1:0] CENTER_RST = {1'b1, {(A-1){1'b0}}};

  // The sequencer walks the x axis and then the y axis through the same states.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_MARK = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_ZONE = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [stc_pkg::ZONE_W-1:0]   dead_zone_q;
  logic [stc_pkg::ZONE_W-1:0]   alive_zone_q;
  logic [stc_pkg::COUNT_W-1:0]  cal_count_q;
  logic [stc_pkg::WEIGHT_W-1:0] cal_weight_q;

  // Per-axis state, entry 0 is x and entry 1 is y.
  logic [A-1:0] center_q [2];
  logic [A-1:0] low_q    [2];
  logic [A-1:0] high_q   [2];
  logic [A-1:0] samp_q   [2];
  logic signed [stc_pkg::VALUE_W-1:0] res_q [2];

  logic [stc_pkg::COUNT_W-1:0] cal_remaining_q;
  logic                        cal_active_q;
  logic                        avg_q;
  logic                        ax_q;

  // Shared datapath registers.
  logic signed [PROD_W-1:0] prod_q;
  logic [A-1:0]             span_q;
  logic [A-1:0]             rem_q;
  logic [N-1:0]             dq_q;
  logic [CNT_W-1:0]         cnt_q;
  logic                     neg_q;
  logic                     zero_q;

  // Output register.
  logic                               out_valid_q;
  logic signed [stc_pkg::VALUE_W-1:0] out_x_q;
  logic signed [stc_pkg::VALUE_W-1:0] out_y_q;
  logic                               out_cal_q;

  logic in_xfer, out_xfer, cfg_xfer, out_load;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid & in_i.ready;
  assign cfg_xfer    = cfg_i.valid & cfg_i.ready;
  assign out_xfer    = out_valid_q & out_o.ready;
  assign out_load    = (state_q == S_DONE) & (~out_valid_q | out_o.ready);

  assign out_o.valid       = out_valid_q;
  assign out_o.x_value     = out_x_q;
  assign out_o.y_value     = out_y_q;
  assign out_o.calibrating = out_cal_q;

  // Weighted average: center + floor((sample - center) * w / 2^16), which equals
  // the truncated blend of center and sample with weights (1 - w) and w.
  logic [stc_pkg::WEIGHT_W-1:0] w_sat;
  logic signed [A:0]            avg_diff;
  logic signed [PROD_W-1:0]     prod_sh;
  logic [A-1:0]                 center_new;

  assign w_sat      = (cal_weight_q > stc_pkg::WEIGHT_ONE) ? stc_pkg::WEIGHT_ONE : cal_weight_q;
  assign avg_diff   = $signed({1'b0, samp_q[ax_q]}) - $signed({1'b0, center_q[ax_q]});
  assign prod_sh    = prod_q >>> 16;
  assign center_new = center_q[ax_q] + prod_sh[A-1:0];

  // Mark update and choice of numerator and span for the current axis.
  logic [A-1:0] s_cur, c_cur, low_new, high_new, num_sel, span_sel;
  logic         above;

  always_comb begin
    s_cur    = samp_q[ax_q];
    c_cur    = center_q[ax_q];
    low_new  = (s_cur < low_q[ax_q])  ? s_cur : low_q[ax_q];
    high_new = (s_cur > high_q[ax_q]) ? s_cur : high_q[ax_q];
    above    = (s_cur > c_cur);
    if (above) begin
      num_sel  = s_cur - c_cur;
      span_sel = high_new - c_cur;
    end else begin
      num_sel  = c_cur - s_cur;
      span_sel = c_cur - low_new;
    end
  end

  // One restoring division step.
  logic [A:0]   trial;
  logic [A:0]   trial_sub;
  logic         trial_ge;

  assign trial     = {rem_q, dq_q[N-1]};
  assign trial_ge  = (trial >= {1'b0, span_q});
  assign trial_sub = trial - {1'b0, span_q};

  // Zone test and sign on the quotient.
  logic [MAG_W-1:0]             mag;
  logic [V_W-1:0]               mag_v, mag_neg;
  logic                         zone_pass;
  logic signed [stc_pkg::VALUE_W-1:0] zone_val;

  always_comb begin
    mag       = dq_q[MAG_W-1:0];
    mag_v     = V_W'(mag);
    mag_neg   = -mag_v;
    zone_pass = ~zero_q && (CMP_W'(mag) > CMP_W'(dead_zone_q))
                        && (CMP_W'(mag) < CMP_W'(alive_zone_q));
    if (!zone_pass) begin
      zone_val = '0;
    end else if (neg_q) begin
      zone_val = $signed(mag_neg[stc_pkg::VALUE_W-1:0]);
    end else begin
      zone_val = $signed(mag_v[stc_pkg::VALUE_W-1:0]);
    end
  end

  logic avg_now;
  assign avg_now = cal_active_q && (cal_remaining_q != '0);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (in_i.op == stc_pkg::OP_SAMPLE)) begin
          state_d = avg_now ? S_MUL : S_MARK;
        end
      end
      S_MUL:  state_d = S_ACC;
      S_ACC:  state_d = S_MARK;
      S_MARK: begin
        state_d = ((num_sel == '0) || (span_sel == '0)) ? S_ZONE : S_DIV;
      end
      S_DIV: begin
        if (cnt_q == CNT_W'(N - 1)) begin
          state_d = S_ZONE;
        end
      end
      S_ZONE: begin
        if (!ax_q) begin
          state_d = avg_q ? S_MUL : S_MARK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      dead_zone_q     <= stc_pkg::DEAD_ZONE_RST;
      alive_zone_q    <= stc_pkg::ALIVE_ZONE_RST;
      cal_count_q     <= stc_pkg::CAL_COUNT_RST;
      cal_weight_q    <= stc_pkg::WEIGHT_ONE;
      center_q[0]     <= CENTER_RST;
      center_q[1]     <= CENTER_RST;
      low_q[0]        <= '1;
      low_q[1]        <= '1;
      high_q[0]       <= '0;
      high_q[1]       <= '0;
      cal_remaining_q <= '0;
      cal_active_q    <= 1'b0;
      avg_q           <= 1'b0;
      ax_q            <= 1'b0;
      cnt_q           <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_xfer) begin
        case (cfg_i.index)
          stc_pkg::CFG_DEAD_ZONE:  dead_zone_q  <= cfg_i.data[stc_pkg::ZONE_W-1:0];
          stc_pkg::CFG_ALIVE_ZONE: alive_zone_q <= cfg_i.data[stc_pkg::ZONE_W-1:0];
          stc_pkg::CFG_CAL_COUNT:  cal_count_q  <= cfg_i.data[stc_pkg::COUNT_W-1:0];
          stc_pkg::CFG_CAL_WEIGHT: cal_weight_q <= cfg_i.data;
          default: ;
        endcase
      end

      // A load in the same cycle refills the register instead.
      if (out_xfer && !out_load) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_i.op == stc_pkg::OP_CAL_START) begin
              // Calibration start reloads the count and keeps centers and marks.
              cal_remaining_q <= cal_count_q;
              cal_active_q    <= 1'b1;
            end else begin
              samp_q[0] <= in_i.x_sample;
              samp_q[1] <= in_i.y_sample;
              ax_q      <= 1'b0;
              avg_q     <= avg_now;
              if (avg_now) begin
                cal_remaining_q <= cal_remaining_q - 1'b1;
              end else if (cal_active_q) begin
                // The first pair after the count runs out ends calibration.
                cal_active_q <= 1'b0;
              end
            end
          end
        end
        S_MUL: begin
          prod_q <= PROD_W'(avg_diff * $signed({1'b0, w_sat}));
        end
        S_ACC: begin
          center_q[ax_q] <= center_new;
        end
        S_MARK: begin
          low_q[ax_q]  <= low_new;
          high_q[ax_q] <= high_new;
          span_q       <= span_sel;
          neg_q        <= ~above;
          zero_q       <= (num_sel == '0) || (span_sel == '0);
          rem_q        <= '0;
          dq_q         <= {num_sel, {F{1'b0}}};
          cnt_q        <= '0;
        end
        S_DIV: begin
          rem_q <= trial_ge ? trial_sub[A-1:0] : trial[A-1:0];
          dq_q  <= {dq_q[N-2:0], trial_ge};
          cnt_q <= cnt_q + 1'b1;
        end
        S_ZONE: begin
          res_q[ax_q] <= zone_val;
          ax_q        <= 1'b1;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_x_q     <= res_q[0];
            out_y_q     <= res_q[1];
            out_cal_q   <= cal_active_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ sv/stc_checker.sv @@
// Port-level checker for the stick conditioner, with its bind statement.
`include "two_axis_stick_conditioner_core_macros.svh"

module stc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                in_op_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [stc_pkg::VALUE_W-1:0] out_x_value_i,
  input logic signed [stc_pkg::VALUE_W-1:0] out_y_value_i,
  input logic                                out_calibrating_i
);

  logic sample_xfer, cal_xfer, out_stall;
  logic [2*stc_pkg::VALUE_W:0] out_payload;
  assign sample_xfer = in_valid_i && in_ready_i && (in_op_i == stc_pkg::OP_SAMPLE);
  assign cal_xfer    = in_valid_i && in_ready_i && (in_op_i == stc_pkg::OP_CAL_START);
  assign out_stall   = out_valid_i && !out_ready_i;
  assign out_payload = {out_x_value_i, out_y_value_i, out_calibrating_i};

  `STC_ASSERT(a_out_hold, out_stall |=> out_valid_i && $stable(out_payload), "held result changed")

  `STC_ASSERT(a_busy_after_sample, sample_xfer |=> !in_ready_i, "ready right after a sample transfer")

  `STC_ASSERT(a_cal_no_result, cal_xfer |=> !$rose(out_valid_i), "calibration start produced a result")

endmodule

bind two_axis_stick_conditioner_core stc_checker u_stc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_op_i           (in_i.op),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_x_value_i     (out_o.x_value),
  .out_y_value_i     (out_o.y_value),
  .out_calibrating_i (out_o.calibrating)
);
